### sv/assert_macros.svh
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds on every clock outside reset
`define CFPC_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent holds on the clock after the antecedent
`define CFPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// condition holds on the clock after a reset clock
`define CFPC_ASSERT_AFTER_RESET(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) !rst_n |=> (expr)) else $error(msg);

`endif

### sv/cfpc_pkg.sv
// types, constants and crc function for the framed packet checker
package cfpc_pkg;

  localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT     = 32'hFFFFFFFF;
  localparam logic [31:0] PACKET_MAGIC = 32'h54445541;
  localparam logic [4:0]  HDR_BYTES    = 5'd16;
  localparam logic [4:0]  HDR_CRC_SPAN = 5'd12;

  typedef logic [4:0] cnt_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_TEST = 2'd1,
    ST_CSUM_ERR = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] seq;
    logic [31:0] pay;
  } verdict_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

### sv/cfpc_in_reg.sv
// input register stage holding one byte transfer
module cfpc_in_reg
  import cfpc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  item_t in_item,
  output logic  in_ready,
  input  logic  take,
  output logic  s1_vld,
  output item_t s1_item
);

  logic  vld_r;
  logic  vld_nxt;
  item_t item_r;

  assign in_ready = !vld_r || take;

  always_comb begin
    vld_nxt = vld_r;
    if (in_valid && in_ready) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign s1_vld  = vld_r;
  assign s1_item = item_r;

endmodule

### sv/cfpc_core.sv
// header capture, running crcs and packet verdict
module cfpc_core
  import cfpc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     go,
  input  item_t    item,
  output logic     res_vld,
  output verdict_t verdict
);

  cnt_t        cnt_r, cnt_nxt;
  logic [31:0] magic_r, magic_nxt;
  logic [31:0] seqw_r, seqw_nxt;
  logic [31:0] spay_r, spay_nxt;
  logic [31:0] shdr_r, shdr_nxt;
  logic [31:0] hcrc_r, hcrc_nxt;
  logic [31:0] pcrc_r, pcrc_nxt;
  logic [4:0]  lane;

  assign lane = {cnt_r[1:0], 3'b000};

  always_comb begin
    cnt_nxt   = cnt_r;
    magic_nxt = magic_r;
    seqw_nxt  = seqw_r;
    spay_nxt  = spay_r;
    shdr_nxt  = shdr_r;
    hcrc_nxt  = hcrc_r;
    pcrc_nxt  = pcrc_r;
    if (cnt_r < HDR_BYTES) begin
      case (cnt_r[3:2])
        2'd0: magic_nxt[lane +: 8] = item.data;
        2'd1: seqw_nxt[lane +: 8]  = item.data;
        2'd2: spay_nxt[lane +: 8]  = item.data;
        default: shdr_nxt[lane +: 8] = item.data;
      endcase
      if (cnt_r < HDR_CRC_SPAN) begin
        hcrc_nxt = crc_byte(hcrc_r, item.data);
      end
      cnt_nxt = cnt_r + 5'd1;
    end else begin
      pcrc_nxt = crc_byte(pcrc_r, item.data);
    end
  end

  always_comb begin
    verdict.status = ST_OK;
    verdict.seq    = 32'd0;
    verdict.pay    = 32'd0;
    if (cnt_nxt < HDR_BYTES || magic_nxt != PACKET_MAGIC) begin
      verdict.status = ST_NOT_TEST;
    end else if (shdr_nxt != ~hcrc_nxt || spay_nxt != ~pcrc_nxt) begin
      verdict.status = ST_CSUM_ERR;
    end else begin
      verdict.seq = seqw_nxt;
      verdict.pay = spay_nxt;
    end
  end

  assign res_vld = go && item.last;

  always_ff @(posedge clk) begin
    if (!rst_n || (go && item.last)) begin
      cnt_r   <= '0;
      magic_r <= '0;
      seqw_r  <= '0;
      spay_r  <= '0;
      shdr_r  <= '0;
      hcrc_r  <= CRC_INIT;
      pcrc_r  <= CRC_INIT;
    end else if (go) begin
      cnt_r   <= cnt_nxt;
      magic_r <= magic_nxt;
      seqw_r  <= seqw_nxt;
      spay_r  <= spay_nxt;
      shdr_r  <= shdr_nxt;
      hcrc_r  <= hcrc_nxt;
      pcrc_r  <= pcrc_nxt;
    end
  end

endmodule

### sv/cfpc_out_reg.sv
// result register holding one verdict until transferred
module cfpc_out_reg
  import cfpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  verdict_t    verdict,
  output logic        slot_free,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_sequence_number,
  output logic [31:0] out_payload_check
);

  logic     vld_r;
  logic     vld_nxt;
  verdict_t res_r;

  assign slot_free = !vld_r || out_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= verdict;
    end
  end

  assign out_valid           = vld_r;
  assign out_status          = res_r.status;
  assign out_sequence_number = res_r.seq;
  assign out_payload_check   = res_r.pay;

endmodule

### sv/crc_framed_packet_checker.sv
// top level of the crc-32 framed packet checker
//
//   channel  direction  fields
//   in_      input      data_byte[7:0], last_byte
//   out_     output     status[1:0], sequence_number[31:0], payload_check[31:0]
//
// one byte accepted per cycle unless stalled by a held verdict; the verdict is registered in the result register
// the byte-wide crc update sits between the input register and the result register
// synchronous active-low reset clears the byte count, header words, both crcs and both valid flags
// a held verdict stalls the input only when the next byte to process is a last byte
module crc_framed_packet_checker
  import cfpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_sequence_number,
  output logic [31:0] out_payload_check
);

  item_t    in_item;
  item_t    s1_item;
  logic     s1_vld;
  logic     go;
  logic     slot_free;
  logic     res_vld;
  verdict_t verdict;

  assign in_item.data = in_data_byte;
  assign in_item.last = in_last_byte;

  assign go = s1_vld && (!s1_item.last || slot_free);

  cfpc_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_item  (in_item),
    .in_ready (in_ready),
    .take     (go),
    .s1_vld   (s1_vld),
    .s1_item  (s1_item)
  );

  cfpc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (go),
    .item    (s1_item),
    .res_vld (res_vld),
    .verdict (verdict)
  );

  cfpc_out_reg u_out_reg (
    .clk                 (clk),
    .rst_n               (rst_n),
    .load                (res_vld),
    .verdict             (verdict),
    .slot_free           (slot_free),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_sequence_number (out_sequence_number),
    .out_payload_check   (out_payload_check)
  );

endmodule

### sv/cfpc_checker.sv
// port-level assertions for the framed packet checker and their bind
`include "assert_macros.svh"

module cfpc_checker
  import cfpc_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  in_data_byte,
  input logic        in_last_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [31:0] out_sequence_number,
  input logic [31:0] out_payload_check
);

  `CFPC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_sequence_number) && $stable(out_payload_check), "stalled verdict changed")
  `CFPC_ASSERT_ALWAYS(a_status_code, !out_valid || out_status == ST_OK || out_status == ST_NOT_TEST || out_status == ST_CSUM_ERR, "undefined status code")
  `CFPC_ASSERT_ALWAYS(a_err_zero, !out_valid || out_status == ST_OK || (out_sequence_number == 32'd0 && out_payload_check == 32'd0), "error verdict with nonzero fields")
  `CFPC_ASSERT_AFTER_RESET(a_reset_empty, !out_valid, "verdict present after reset")

endmodule

bind crc_framed_packet_checker cfpc_checker u_cfpc_checker (.*);
